@@ design/swrms_pkg.sv @@
// Shared types and constants for the sliding-window RMS block.
package swrms_pkg;

   localparam int LEVEL_W        = 31;
   localparam int MODE_W         = 2;
   localparam int COEF_W         = 16;
   localparam int COEF_FRAC_BITS = 15;
   localparam int CSR_W          = 16;

   localparam logic [MODE_W-1:0]  MODE_RMS    = 2'd0;
   localparam logic [MODE_W-1:0]  MODE_RECIP  = 2'd1;
   localparam logic [MODE_W-1:0]  MODE_SCALED = 2'd2;

   localparam logic CSR_RESULT_MODE = 1'b0;
   localparam logic CSR_FORM_COEF   = 1'b1;

   localparam logic [COEF_W-1:0]  COEF_RESET      = 16'd36397;
   localparam logic [LEVEL_W-1:0] RECIP_NUMERATOR = 31'h4000_0000;

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_READ_OLD  = 9'b000000010,
      ST_ADD_NEW   = 9'b000000100,
      ST_SUM       = 9'b000001000,
      ST_SCALE_MUL = 9'b000010000,
      ST_SCALE_DIV = 9'b000100000,
      ST_DIV       = 9'b001000000,
      ST_SQRT      = 9'b010000000,
      ST_DONE      = 9'b100000000
   } state_type;

   typedef enum logic [1:0] {
      DIV_MEAN  = 2'd0,
      DIV_RECIP = 2'd1,
      DIV_SCALE = 2'd2
   } div_kind_type;

endpackage

@@ design/swrms_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module swrms_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/sliding_window_rms.sv @@
// Sliding-window RMS / reciprocal RMS / scaled mean-absolute level meter.
//
// Usage:
//  - req_ channel (valid/ready) carries one signed sample per transaction.
//    req_ready is high only while the sequencer is idle.
//  - rsp_ channel (valid/ready) returns one level per sample: rsp_level and
//    rsp_zero_level. A finished result sits in the output register, so the
//    next sample is taken while the receiver stalls; the sequencer only
//    waits in its final state if the output register is still occupied.
//  - csr_ port: write-only, csr_index 0 = result mode, 1 = form coefficient.
//    Write only while idle.
// Sequence, accept to rsp_valid: read old entry, add new sample, sum, then
//    mode 0/3: square root, mode 1: square root and divide (no divide when
//    the rms is zero), mode 2: scale multiply; a divide by W is added when
//    WINDOW is not a power of two. req_ready returns with rsp_valid.
//  Divides and roots run on the shared shift/compare/subtract unit, which
//  does one quotient bit or one root bit per cycle.
// Reset: synchronous; sums, pointer and fill flag cleared, registers to
// their reset values. The window RAM is not cleared: a fill flag masks
// entries until the pointer has wrapped once, so they read as zero.
module sliding_window_rms
   import swrms_pkg::*;
#(
   parameter int WINDOW      = 64,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [LEVEL_W-1:0]            rsp_level,
   output logic                          rsp_zero_level,
   input  logic                          csr_write_en,
   input  logic                          csr_index,
   input  logic [CSR_W-1:0]              csr_wdata
);

   // Derived widths
   localparam int SB         = SAMPLE_BITS;
   localparam int LOG_W      = $clog2(WINDOW);
   localparam bit W_POW2     = ((1 << LOG_W) == WINDOW);
   localparam int SQ_W       = 2 * SB - 1 + LOG_W;   // sum of squares
   localparam int ABS_W      = SB + LOG_W;           // sum of magnitudes
   localparam int ROOT_W     = SB;
   localparam int NUM_W      = (SQ_W > LEVEL_W) ? SQ_W : LEVEL_W;
   localparam int SQRT_SHIFT = NUM_W - 2 * ROOT_W;
   localparam int OP_W       = (ROOT_W + 2 > LOG_W + 1) ? ROOT_W + 2 : LOG_W + 1;
   localparam int REM_W      = OP_W + 1;
   localparam int MA_W       = ABS_W;
   localparam int MB_W       = (SB > COEF_W) ? SB : COEF_W;
   localparam int P_W        = MA_W + MB_W;
   localparam int CNT_W      = $clog2(NUM_W + 1);

   // Sequencer and window state
   state_type          state_ff, state_in;
   logic [LOG_W-1:0]   ptr_ff, ptr_in;
   logic               full_ff, full_in;
   logic [SQ_W-1:0]    sq_ff, sq_in;
   logic [ABS_W-1:0]   abs_ff, abs_in;
   logic [SB-1:0]      raw_ff, raw_in;

   // Configuration
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [COEF_W-1:0]  coef_ff, coef_in;

   // Shared divide / square-root unit
   logic [NUM_W-1:0]   num_ff, num_in;
   logic [REM_W-1:0]   rem_ff, rem_in;
   logic [NUM_W-1:0]   q_ff, q_in;
   logic [OP_W-1:0]    den_ff, den_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   div_kind_type       kind_ff, kind_in;

   logic               is_sqrt;
   logic [REM_W-1:0]   rem_sh, trial, rem_step;
   logic               ge;
   logic [NUM_W-1:0]   q_step, num_step;
   logic [ROOT_W-1:0]  root;

   // Shared multiplier
   logic [MA_W-1:0]    mul_a;
   logic [MB_W-1:0]    mul_b;
   logic [P_W-1:0]     prod_ff;

   // Result holding and output register
   logic [LEVEL_W-1:0] res_level_ff, res_level_in;
   logic               res_zero_ff, res_zero_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic               rsp_zero_level_ff, rsp_zero_level_in;

   // Window RAM
   logic               ram_wr_en;
   logic [SB-1:0]      ram_rd_data;

   logic [SB-1:0]      old_mag, new_mag;
   logic [NUM_W-1:0]   scaled;

   swrms_ram #(
      .WIDTH (SB),
      .DEPTH (WINDOW)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ptr_ff),
      .wr_data (raw_ff),
      .rd_addr (ptr_ff),
      .rd_data (ram_rd_data)
   );

   // Magnitudes; the most negative code maps to 2^(SB-1) exactly.
   // Entries not yet written since reset read as zero.
   always_comb begin
      if (!full_ff) begin
         old_mag = '0;
      end else if (ram_rd_data[SB-1]) begin
         old_mag = ~ram_rd_data + 1'b1;
      end else begin
         old_mag = ram_rd_data;
      end
      if (raw_ff[SB-1]) begin
         new_mag = ~raw_ff + 1'b1;
      end else begin
         new_mag = raw_ff;
      end
   end

   // One step of restoring division (1 bit) or digit-by-digit root (2 bits)
   assign is_sqrt  = (state_ff == ST_SQRT);
   assign rem_sh   = is_sqrt ? {rem_ff[REM_W-3:0], num_ff[NUM_W-1 -: 2]}
                             : {rem_ff[REM_W-2:0], num_ff[NUM_W-1]};
   assign trial    = is_sqrt ? REM_W'({q_ff[ROOT_W-1:0], 2'b01}) : REM_W'(den_ff);
   assign ge       = (rem_sh >= trial);
   assign rem_step = ge ? (rem_sh - trial) : rem_sh;
   assign q_step   = {q_ff[NUM_W-2:0], ge};
   assign num_step = is_sqrt ? (num_ff << 2) : (num_ff << 1);
   assign root     = q_step[ROOT_W-1:0];

   assign scaled   = NUM_W'(prod_ff >> COEF_FRAC_BITS);

   always_comb begin
      state_in          = state_ff;
      ptr_in            = ptr_ff;
      full_in           = full_ff;
      sq_in             = sq_ff;
      abs_in            = abs_ff;
      raw_in            = raw_ff;
      num_in            = num_ff;
      rem_in            = rem_ff;
      q_in              = q_ff;
      den_in            = den_ff;
      cnt_in            = cnt_ff;
      kind_in           = kind_ff;
      res_level_in      = res_level_ff;
      res_zero_in       = res_zero_ff;
      mul_a             = '0;
      mul_b             = '0;
      ram_wr_en         = 1'b0;
      rsp_valid_in      = rsp_valid_ff & ~rsp_ready;
      rsp_level_in      = rsp_level_ff;
      rsp_zero_level_in = rsp_zero_level_ff;
      mode_in           = mode_ff;
      coef_in           = coef_ff;

      if (csr_write_en) begin
         unique case (csr_index)
            CSR_RESULT_MODE: mode_in = csr_wdata[MODE_W-1:0];
            CSR_FORM_COEF:   coef_in = csr_wdata[COEF_W-1:0];
            default:         mode_in = mode_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               raw_in   = req_sample;
               state_in = ST_READ_OLD;
            end
         end
         // RAM data for the oldest entry is here; square it, overwrite it
         ST_READ_OLD: begin
            mul_a     = MA_W'(old_mag);
            mul_b     = MB_W'(old_mag);
            abs_in    = abs_ff - ABS_W'(old_mag);
            ram_wr_en = 1'b1;
            state_in  = ST_ADD_NEW;
         end
         ST_ADD_NEW: begin
            sq_in  = sq_ff - SQ_W'(prod_ff);
            mul_a  = MA_W'(new_mag);
            mul_b  = MB_W'(new_mag);
            abs_in = abs_ff + ABS_W'(new_mag);
            if (ptr_ff == LOG_W'(WINDOW - 1)) begin
               ptr_in  = '0;
               full_in = 1'b1;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
            state_in = ST_SUM;
         end
         ST_SUM: begin
            sq_in = sq_ff + SQ_W'(prod_ff);
            rem_in = '0;
            q_in   = '0;
            if (mode_ff == MODE_SCALED) begin
               state_in = ST_SCALE_MUL;
            end else if (W_POW2) begin
               num_in   = (NUM_W'(sq_in) >> LOG_W) << SQRT_SHIFT;
               cnt_in   = CNT_W'(ROOT_W);
               state_in = ST_SQRT;
            end else begin
               num_in   = NUM_W'(sq_in);
               den_in   = OP_W'(WINDOW);
               cnt_in   = CNT_W'(NUM_W);
               kind_in  = DIV_MEAN;
               state_in = ST_DIV;
            end
         end
         ST_SCALE_MUL: begin
            mul_a    = abs_ff;
            mul_b    = MB_W'(coef_ff);
            state_in = ST_SCALE_DIV;
         end
         ST_SCALE_DIV: begin
            if (W_POW2) begin
               res_level_in = LEVEL_W'(scaled >> LOG_W);
               res_zero_in  = 1'b0;
               state_in     = ST_DONE;
            end else begin
               num_in   = scaled;
               rem_in   = '0;
               q_in     = '0;
               den_in   = OP_W'(WINDOW);
               cnt_in   = CNT_W'(NUM_W);
               kind_in  = DIV_SCALE;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            num_in = num_step;
            rem_in = rem_step;
            q_in   = q_step;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               if (kind_ff == DIV_MEAN) begin
                  num_in   = q_step << SQRT_SHIFT;
                  rem_in   = '0;
                  q_in     = '0;
                  cnt_in   = CNT_W'(ROOT_W);
                  state_in = ST_SQRT;
               end else begin
                  res_level_in = q_step[LEVEL_W-1:0];
                  res_zero_in  = 1'b0;
                  state_in     = ST_DONE;
               end
            end
         end
         ST_SQRT: begin
            num_in = num_step;
            rem_in = rem_step;
            q_in   = q_step;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               if (mode_ff == MODE_RECIP) begin
                  if (root == '0) begin
                     res_level_in = '0;
                     res_zero_in  = 1'b1;
                     state_in     = ST_DONE;
                  end else begin
                     num_in   = NUM_W'(RECIP_NUMERATOR);
                     rem_in   = '0;
                     q_in     = '0;
                     den_in   = OP_W'(root);
                     cnt_in   = CNT_W'(NUM_W);
                     kind_in  = DIV_RECIP;
                     state_in = ST_DIV;
                  end
               end else begin
                  res_level_in = LEVEL_W'(root);
                  res_zero_in  = 1'b0;
                  state_in     = ST_DONE;
               end
            end
         end
         // Hand over to the output register once it is free
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_level_in      = res_level_ff;
               rsp_zero_level_in = res_zero_ff;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ptr_ff       <= '0;
         full_ff      <= 1'b0;
         sq_ff        <= '0;
         abs_ff       <= '0;
         mode_ff      <= MODE_RMS;
         coef_ff      <= COEF_RESET;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         kind_ff      <= DIV_MEAN;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         full_ff      <= full_in;
         sq_ff        <= sq_in;
         abs_ff       <= abs_in;
         mode_ff      <= mode_in;
         coef_ff      <= coef_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
         kind_ff      <= kind_in;
      end
   end

   // Datapath, no reset needed
   always_ff @(posedge clock) begin
      raw_ff            <= raw_in;
      num_ff            <= num_in;
      rem_ff            <= rem_in;
      q_ff              <= q_in;
      den_ff            <= den_in;
      prod_ff           <= mul_a * mul_b;
      res_level_ff      <= res_level_in;
      res_zero_ff       <= res_zero_in;
      rsp_level_ff      <= rsp_level_in;
      rsp_zero_level_ff <= rsp_zero_level_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_level      = rsp_level_ff;
   assign rsp_zero_level = rsp_zero_level_ff;

   // Restoring division keeps the partial remainder below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (REM_W'(den_ff) > rem_ff))
      else $error("divider remainder not below divisor");

   // Root iteration count stays within the root width
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT) |-> (cnt_ff != '0 && cnt_ff <= CNT_W'(ROOT_W)))
      else $error("square-root step count out of range");

   // Running magnitude sum never exceeds a full window of largest magnitudes
   assert property (@(posedge clock) disable iff (reset)
      abs_ff <= (ABS_W'(WINDOW) << (SB - 1)))
      else $error("magnitude sum out of range");

   // Once the pointer has wrapped, the window stays full
   assert property (@(posedge clock) disable iff (reset)
      !$fell(full_ff))
      else $error("fill flag dropped");

   // Zero flag only ever goes with a zero level
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_zero_level_ff) |-> (rsp_level_ff == '0))
      else $error("zero flag with non-zero level");

endmodule
